// ===== sv/cms_pkg.sv =====
// Shared types, constants and defaults for the count-min sketch.
// Depends on nothing; used by every module of the sketch.
package cms_pkg;

    localparam logic [63:0] MM_MUL   = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] MM_MUL8  = 64'(MM_MUL << 3);
    localparam int          MM_SHIFT = 47;

    localparam int DEF_MAX_ROWS   = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_COUNT_BITS = 32;

    localparam int ROW_W   = 4;
    localparam int WIDTH_W = 11;
    localparam int SEED_W  = 31;
    localparam int PHI_W   = 17;
    localparam int TOT_W   = 32;
    localparam int EST_W   = 32;
    localparam int REM_W   = 11;
    localparam int CIDX_W  = 4;
    localparam int CDAT_W  = 32;
    localparam int STEP_W  = 4;
    localparam int DIV_BITS = 4;
    localparam int MUL_PHASES = 4;

    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

    localparam logic [CIDX_W-1:0] CFG_ROWS  = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_SEED  = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_PHI   = 4'd3;

    localparam logic [ROW_W-1:0]   RST_ROWS  = 4'd4;
    localparam logic [WIDTH_W-1:0] RST_WIDTH = 11'd1024;
    localparam logic [SEED_W-1:0]  RST_SEED  = '0;
    localparam logic [PHI_W-1:0]   RST_PHI   = 17'd6554;

    typedef struct packed {
        logic             clr;
        logic             accept;
        logic             mul_en;
        logic [1:0]       mul_ph;
        logic             xsh;
        logic             save_k;
        logic             ld_row;
        logic             div_step;
        logic             rd;
        logic             rmw;
        logic             first;
        logic             fin;
        logic             ld_out;
        logic [ROW_W-1:0] row;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/cms_ctrl.sv =====
// Controller state machine of the count-min sketch.
// Depends on cms_pkg; drives the datapath cms_dp by command and status structs.
module cms_ctrl #(
    parameter int MAX_ROWS = cms_pkg::DEF_MAX_ROWS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [cms_pkg::ROW_W-1:0] rows_in_use,
    output cms_pkg::cmd_t             cmd,
    input  cms_pkg::sts_t             sts
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_KMUL1 = 4'd2;
    localparam logic [3:0] ST_KSH   = 4'd3;
    localparam logic [3:0] ST_KMUL2 = 4'd4;
    localparam logic [3:0] ST_KSAVE = 4'd5;
    localparam logic [3:0] ST_ROW   = 4'd6;
    localparam logic [3:0] ST_HMUL1 = 4'd7;
    localparam logic [3:0] ST_HSH1  = 4'd8;
    localparam logic [3:0] ST_HMUL2 = 4'd9;
    localparam logic [3:0] ST_HSH2  = 4'd10;
    localparam logic [3:0] ST_DIV   = 4'd11;
    localparam logic [3:0] ST_RD    = 4'd12;
    localparam logic [3:0] ST_RMW   = 4'd13;
    localparam logic [3:0] ST_FIN   = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    localparam logic [cms_pkg::STEP_W-1:0] MUL_LAST =
        cms_pkg::STEP_W'(cms_pkg::MUL_PHASES - 1);
    localparam logic [cms_pkg::STEP_W-1:0] DIV_LAST =
        cms_pkg::STEP_W'(64 / cms_pkg::DIV_BITS - 1);

    logic [3:0]                  state_reg, state_next;
    logic [cms_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [cms_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [cms_pkg::ROW_W-1:0]   last_row;

    always_comb begin
        if (rows_in_use == '0) begin
            last_row = '0;
        end else if (int'(rows_in_use) > MAX_ROWS) begin
            last_row = cms_pkg::ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = rows_in_use - 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.mul_ph = step_reg[1:0];
        cmd.first  = (row_reg == '0);
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    step_next  = '0;
                    row_next   = '0;
                    state_next = ST_KMUL1;
                end
            end
            ST_KMUL1, ST_KMUL2, ST_HMUL1, ST_HMUL2: begin
                cmd.mul_en = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == MUL_LAST) begin
                    step_next = '0;
                    unique case (state_reg)
                        ST_KMUL1: state_next = ST_KSH;
                        ST_KMUL2: state_next = ST_KSAVE;
                        ST_HMUL1: state_next = ST_HSH1;
                        default:  state_next = ST_HSH2;
                    endcase
                end
            end
            ST_KSH: begin
                cmd.xsh    = 1'b1;
                state_next = ST_KMUL2;
            end
            ST_KSAVE: begin
                cmd.save_k = 1'b1;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                cmd.ld_row = 1'b1;
                state_next = ST_HMUL1;
            end
            ST_HSH1: begin
                cmd.xsh    = 1'b1;
                state_next = ST_HMUL2;
            end
            ST_HSH2: begin
                cmd.xsh    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    step_next  = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_RMW;
            end
            ST_RMW: begin
                cmd.rmw = 1'b1;
                if (row_reg == last_row) begin
                    state_next = ST_FIN;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== sv/cms_dp.sv =====
// Datapath of the count-min sketch: hash unit, modulo unit, counter memory
// and result register. Depends on cms_pkg; sequenced by cms_ctrl.
module cms_dp #(
    parameter int MAX_ROWS   = cms_pkg::DEF_MAX_ROWS,
    parameter int MAX_WIDTH  = cms_pkg::DEF_MAX_WIDTH,
    parameter int COUNT_BITS = cms_pkg::DEF_COUNT_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cms_pkg::cmd_t               cmd,
    output cms_pkg::sts_t               sts,
    input  logic                        s_action,
    input  logic [63:0]                 s_item_key,
    input  logic [cms_pkg::WIDTH_W-1:0] row_width,
    input  logic [cms_pkg::SEED_W-1:0]  seed_base,
    input  logic [cms_pkg::PHI_W-1:0]   phi_q16,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cms_pkg::EST_W-1:0]   m_estimate,
    output logic                        m_heavy,
    output logic [cms_pkg::TOT_W-1:0]   m_stream_total
);

    localparam int DEPTH  = MAX_ROWS * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EXT_W  = (COUNT_BITS > cms_pkg::EST_W) ? COUNT_BITS : cms_pkg::EST_W;
    localparam int PROD_W = cms_pkg::PHI_W + cms_pkg::TOT_W;

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic [63:0]                 x_reg, k_reg, acc_reg, pp_reg;
    logic [31:0]                 mul_a, mul_b;
    logic [63:0]                 mul_p;
    logic                        act_reg;
    logic [cms_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [cms_pkg::WIDTH_W-1:0] eff_w;
    logic [ADDR_W-1:0]           clr_addr_reg, addr;
    logic [COUNT_BITS-1:0]       rd_reg, upd, min_reg;
    logic [cms_pkg::TOT_W-1:0]   total_reg;
    logic [cms_pkg::EST_W-1:0]   est_reg;
    logic [EXT_W-1:0]            min_ext;
    logic [PROD_W-1:0]           prod_reg;
    logic [31:0]                 seed;
    logic                        m_valid_reg;
    logic [cms_pkg::EST_W-1:0]   est_out_reg;
    logic                        heavy_reg;
    logic [cms_pkg::TOT_W-1:0]   tot_out_reg;

    always_comb begin
        if (row_width == '0) begin
            eff_w = cms_pkg::WIDTH_W'(1);
        end else if (int'(row_width) > MAX_WIDTH) begin
            eff_w = cms_pkg::WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_w = row_width;
        end
    end

    always_comb begin
        unique case (cmd.mul_ph)
            2'd1:    begin mul_a = x_reg[31:0];  mul_b = cms_pkg::MM_MUL[63:32]; end
            2'd2:    begin mul_a = x_reg[63:32]; mul_b = cms_pkg::MM_MUL[31:0];  end
            default: begin mul_a = x_reg[31:0];  mul_b = cms_pkg::MM_MUL[31:0];  end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Four remainder bits per step, most significant hash bits first.
    always_comb begin
        logic [cms_pkg::REM_W:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < cms_pkg::DIV_BITS; i++) begin
            t = {rem_next, x_reg[63 - i]};
            if (t >= {1'b0, eff_w}) begin
                t = t - {1'b0, eff_w};
            end
            rem_next = t[cms_pkg::REM_W-1:0];
        end
    end

    assign seed = 32'(seed_base) + 32'(cmd.row);
    assign addr = ADDR_W'(cmd.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rem_reg);
    assign upd  = (act_reg == 1'b0 && rd_reg != '1) ? rd_reg + 1'b1 : rd_reg;
    assign min_ext = EXT_W'(min_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x_reg   <= s_item_key;
            act_reg <= s_action;
        end else if (cmd.ld_row) begin
            x_reg   <= ({32'b0, seed} ^ cms_pkg::MM_MUL8) ^ k_reg;
            rem_reg <= '0;
        end else if (cmd.mul_en && cmd.mul_ph == 2'd3) begin
            x_reg <= acc_reg + {pp_reg[31:0], 32'b0};
        end else if (cmd.xsh) begin
            x_reg <= x_reg ^ (x_reg >> cms_pkg::MM_SHIFT);
        end else if (cmd.div_step) begin
            x_reg   <= x_reg << cms_pkg::DIV_BITS;
            rem_reg <= rem_next;
        end
        if (cmd.mul_en) begin
            pp_reg <= mul_p;
            if (cmd.mul_ph == 2'd1) begin
                acc_reg <= pp_reg;
            end else if (cmd.mul_ph == 2'd2) begin
                acc_reg <= acc_reg + {pp_reg[31:0], 32'b0};
            end
        end
        if (cmd.save_k) begin
            k_reg <= x_reg;
        end
        if (cmd.rd) begin
            rd_reg <= mem[addr];
        end
        if (cmd.clr) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.rmw && act_reg == 1'b0) begin
            mem[addr] <= upd;
        end
        if (cmd.rmw && (cmd.first || upd < min_reg)) begin
            min_reg <= upd;
        end
        if (cmd.fin) begin
            est_reg  <= (min_ext > EXT_W'(cms_pkg::TOTAL_MAX)) ? cms_pkg::TOTAL_MAX
                                                                : min_ext[cms_pkg::EST_W-1:0];
            prod_reg <= PROD_W'(phi_q16) * PROD_W'(total_reg);
        end
        if (cmd.ld_out) begin
            est_out_reg <= est_reg;
            heavy_reg   <= (PROD_W'({est_reg, 16'b0}) >= prod_reg);
            tot_out_reg <= total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clr) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.accept && !s_action && total_reg != cms_pkg::TOTAL_MAX) begin
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_estimate     = est_out_reg;
    assign m_heavy        = heavy_reg;
    assign m_stream_total = tot_out_reg;

endmodule

// ===== sv/count_min_sketch.sv =====
// Top level of the count-min sketch: configuration registers, controller and datapath.
// Depends on cms_pkg, cms_ctrl and cms_dp.
//
// Requests enter on the s_ channel (s_action, s_item_key) and results leave on
// the m_ channel (m_estimate, m_heavy, m_stream_total), both valid/ready.
// An action of zero adds the key before estimating; one only estimates.
// Registers are written on the cfg_ channel, index 0 to 3 in the order rows,
// width, seed base and heavy fraction; other indexes are ignored. cfg_ready
// is always high. Write configuration only while no request is in flight.
// One request is worked on at a time. From acceptance to a loaded result it
// runs the key multiplies, then per row two 64-bit multiplies on a shared 32
// by 32 multiplier, the four bit per cycle modulo unit, and a read and a write
// of the counter memory. The result sits in an output register, so a new
// request is taken while a result waits; a stalled receiver holds the next
// result back in the controller. After reset the counter memory is cleared,
// one counter a cycle over all MAX_ROWS * MAX_WIDTH counters, during which
// s_ready stays low.
module count_min_sketch #(
    parameter int MAX_ROWS   = cms_pkg::DEF_MAX_ROWS,
    parameter int MAX_WIDTH  = cms_pkg::DEF_MAX_WIDTH,
    parameter int COUNT_BITS = cms_pkg::DEF_COUNT_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [63:0]                s_item_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [cms_pkg::EST_W-1:0]  m_estimate,
    output logic                       m_heavy,
    output logic [cms_pkg::TOT_W-1:0]  m_stream_total,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cms_pkg::CIDX_W-1:0] cfg_index,
    input  logic [cms_pkg::CDAT_W-1:0] cfg_data
);

    logic [cms_pkg::ROW_W-1:0]   rows_reg;
    logic [cms_pkg::WIDTH_W-1:0] width_reg;
    logic [cms_pkg::SEED_W-1:0]  seed_reg;
    logic [cms_pkg::PHI_W-1:0]   phi_reg;
    cms_pkg::cmd_t               cmd;
    cms_pkg::sts_t               sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= cms_pkg::RST_ROWS;
            width_reg <= cms_pkg::RST_WIDTH;
            seed_reg  <= cms_pkg::RST_SEED;
            phi_reg   <= cms_pkg::RST_PHI;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cms_pkg::CFG_ROWS:  rows_reg  <= cfg_data[cms_pkg::ROW_W-1:0];
                cms_pkg::CFG_WIDTH: width_reg <= cfg_data[cms_pkg::WIDTH_W-1:0];
                cms_pkg::CFG_SEED:  seed_reg  <= cfg_data[cms_pkg::SEED_W-1:0];
                cms_pkg::CFG_PHI:   phi_reg   <= cfg_data[cms_pkg::PHI_W-1:0];
                default: ;
            endcase
        end
    end

    cms_ctrl #(
        .MAX_ROWS(MAX_ROWS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .rows_in_use(rows_reg),
        .cmd        (cmd),
        .sts        (sts)
    );

    cms_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_WIDTH (MAX_WIDTH),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_action      (s_action),
        .s_item_key    (s_item_key),
        .row_width     (width_reg),
        .seed_base     (seed_reg),
        .phi_q16       (phi_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_estimate    (m_estimate),
        .m_heavy       (m_heavy),
        .m_stream_total(m_stream_total)
    );

`ifndef NO_ASSERTIONS
    // Only one request is in flight at a time.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another was in flight");

    // A new result is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> !(m_valid && !m_ready))
        else $error("result overwritten before it was taken");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");
`endif

endmodule
